// ===== rtl/core/bus_1553_manchester_word_decoder_unit_defines.svh =====
// Assertion macros shared by the checker of the word decoder.
// Depends on nothing; included by the checker file.
`ifndef BUS_1553_MANCHESTER_WORD_DECODER_UNIT_DEFINES_SVH
`define BUS_1553_MANCHESTER_WORD_DECODER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define B1553_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define B1553_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/b1553_pkg.sv =====
// Shared types and constants of the 1553 word decoder.
// No dependencies.
package b1553_pkg;
    localparam int TIME_BITS_DEF  = 48;
    localparam int LEVEL_BITS_DEF = 16;
    localparam int OUT_TIME_BITS  = 48;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [3:0] {
        LP_IDLE     = 4'd0,
        LP_CSYNC_HI = 4'd1,
        LP_CSYNC_LO = 4'd2,
        LP_DSYNC_LO = 4'd3,
        LP_DSYNC_HI = 4'd4,
        LP_ZERO_LO  = 4'd5,
        LP_ZERO_HI  = 4'd6,
        LP_ONE_HI   = 4'd7,
        LP_ONE_LO   = 4'd8,
        LP_TURN     = 4'd9
    } line_phase_t;

    typedef enum logic [1:0] {
        FP_IDLE   = 2'd0,
        FP_STATUS = 2'd1,
        FP_DATA   = 2'd2
    } frame_phase_t;

    localparam logic [3:0] K_SYNC_CMD  = 4'd0;
    localparam logic [3:0] K_SYNC_DATA = 4'd1;
    localparam logic [3:0] K_GAP       = 4'd2;
    localparam logic [3:0] K_RT        = 4'd3;
    localparam logic [3:0] K_DIR       = 4'd4;
    localparam logic [3:0] K_SA        = 4'd5;
    localparam logic [3:0] K_LEN       = 4'd6;
    localparam logic [3:0] K_PAR_OK    = 4'd7;
    localparam logic [3:0] K_PAR_BAD   = 4'd8;
    localparam logic [3:0] K_MSG_OK    = 4'd9;
    localparam logic [3:0] K_MSG_ERR   = 4'd10;
    localparam logic [3:0] K_STATUS    = 4'd11;
    localparam logic [3:0] K_DATA      = 4'd12;

    localparam logic [2:0] REG_HIGH      = 3'd0;
    localparam logic [2:0] REG_LOW       = 3'd1;
    localparam logic [2:0] REG_SYNC_HALF = 3'd2;
    localparam logic [2:0] REG_DATA_HALF = 3'd3;
    localparam logic [2:0] REG_GAP       = 3'd4;
    localparam logic [2:0] REG_SYNC_LONG = 3'd5;
    localparam logic [2:0] REG_BIT_LONG  = 3'd6;

    // Work that the front hands to the back for one sample.
    typedef enum logic [1:0] {
        JOB_SYNC = 2'd0,
        JOB_GAP  = 2'd1,
        JOB_WORD = 2'd2
    } job_kind_t;
endpackage

// ===== rtl/core/b1553_front.sv =====
// Front part: slices the line level, runs the Manchester and frame state
// and queues one job per sample that yields symbols. Uses b1553_pkg.
module b1553_front
    import b1553_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid,
    output logic                    stall,
    input  logic [TIME_BITS-1:0]    sample_time,
    input  logic [LEVEL_BITS-1:0]   line_level,
    input  logic [15:0]             high_level,
    input  logic [15:0]             low_level,
    input  logic [23:0]             sync_half_len,
    input  logic [23:0]             data_half_len,
    input  logic [23:0]             gap_len,
    input  logic [23:0]             sync_long_limit,
    input  logic [23:0]             bit_long_limit,
    output logic                    job_valid,
    output job_kind_t               job_kind,
    output logic                    job_sync_data,
    output logic [TIME_BITS-1:0]    job_start,
    output logic [TIME_BITS-1:0]    job_len,
    output logic [TIME_BITS-1:0]    job_t,
    output logic [16:0]             job_word,
    output frame_phase_t            job_frame,
    output logic [TIME_BITS-1:0]    job_m0,
    output logic [TIME_BITS-1:0]    job_m1,
    output logic [TIME_BITS-1:0]    job_m2,
    output logic [TIME_BITS-1:0]    job_m3,
    output logic [TIME_BITS-1:0]    job_m4,
    output logic [5:0]              job_expected,
    input  logic                    job_full
);
    line_phase_t            lp_reg, lp_next;
    frame_phase_t           fp_reg, fp_next;
    logic                   prev_reg, prev_next;
    logic [TIME_BITS-1:0]   bst_reg, bst_next;
    logic [4:0]             nb_reg, nb_next;
    logic [16:0]            sw_reg, sw_next;
    logic [5:0]             seen_reg, seen_next;
    logic [5:0]             exp_reg, exp_next;
    logic                   dir_reg, dir_next;
    logic [TIME_BITS-1:0]   mk_reg [5];
    logic [TIME_BITS-1:0]   mk_next [5];

    logic                   take;
    logic                   cur, lvl_ok, done, pushed, pb;
    logic [TIME_BITS-1:0]   dur, two_data, two_sync;
    logic signed [LEVEL_BITS-1:0] lvl;
    logic signed [23:0]     lvl_w, hi_w, lo_w;
    logic [16:0]            sw_push;
    logic [16:0]            word_done;

    assign stall = job_full;
    assign take  = valid && !job_full;

    function automatic logic longer_f(input logic [TIME_BITS-1:0] d,
                                      input logic [23:0] x);
        longer_f = !d[TIME_BITS-1] && (d > TIME_BITS'(x));
    endfunction

    always_comb
    begin
        lvl      = line_level;
        lvl_w    = 24'(lvl);
        hi_w     = 24'($signed(high_level));
        lo_w     = 24'($signed(low_level));
        dur      = sample_time - bst_reg;
        two_data = TIME_BITS'({data_half_len, 1'b0});
        two_sync = TIME_BITS'({sync_half_len, 1'b0});
        cur      = prev_reg;
        lvl_ok   = 1'b0;
        if (lvl_w > hi_w)
        begin
            cur = 1'b1; lvl_ok = 1'b1;
        end
        else if (lvl_w < lo_w)
        begin
            cur = 1'b0; lvl_ok = 1'b1;
        end
    end

    always_comb
    begin
        lp_next   = lp_reg;
        fp_next   = fp_reg;
        bst_next  = bst_reg;
        nb_next   = nb_reg;
        sw_next   = sw_reg;
        seen_next = seen_reg;
        exp_next  = exp_reg;
        dir_next  = dir_reg;
        for (int i = 0; i < 5; i++) mk_next[i] = mk_reg[i];
        done      = 1'b0;
        pushed    = 1'b0;
        pb        = 1'b0;
        job_valid = 1'b0;
        job_kind  = JOB_SYNC;
        job_sync_data = 1'b0;
        job_start = bst_reg;
        job_len   = dur;
        sw_push   = {sw_reg[15:0], 1'b0};
        if (nb_reg == 5'd16 && !dur[TIME_BITS-1] && dur >= two_data)
        begin
            pushed = 1'b1; pb = (lp_reg == LP_ONE_LO);
            done = 1'b1;
        end
        else if (lvl_ok)
        begin
            case (lp_reg)
                LP_CSYNC_HI: if (!cur) lp_next = LP_CSYNC_LO;
                LP_DSYNC_LO: if (cur) lp_next = LP_DSYNC_HI;
                LP_ZERO_LO:  if (cur) lp_next = LP_ZERO_HI;
                LP_ONE_HI:   if (!cur) lp_next = LP_ONE_LO;
                LP_CSYNC_LO, LP_DSYNC_HI:
                begin
                    if (cur == (lp_reg == LP_CSYNC_LO))
                    begin
                        job_valid = 1'b1;
                        job_kind  = JOB_SYNC;
                        job_sync_data = (lp_reg == LP_DSYNC_HI);
                        if (longer_f(dur, sync_long_limit))
                        begin
                            job_len  = two_sync;
                            bst_next = bst_reg + two_sync;
                            lp_next  = job_sync_data ? LP_ONE_LO : LP_ZERO_HI;
                        end
                        else
                        begin
                            bst_next = sample_time;
                            lp_next  = job_sync_data ? LP_ZERO_LO : LP_ONE_HI;
                        end
                        nb_next = '0;
                        sw_next = '0;
                    end
                end
                LP_ZERO_HI, LP_ONE_LO:
                begin
                    if (cur == (lp_reg == LP_ONE_LO))
                    begin
                        pushed = 1'b1; pb = cur;
                        if (nb_reg == 5'd16)
                            done = 1'b1;
                        else if (longer_f(dur, bit_long_limit))
                        begin
                            bst_next = bst_reg + two_data;
                            lp_next  = cur ? LP_ZERO_HI : LP_ONE_LO;
                        end
                        else
                        begin
                            bst_next = sample_time;
                            lp_next  = cur ? LP_ONE_HI : LP_ZERO_LO;
                        end
                    end
                end
                LP_TURN:
                begin
                    if (longer_f(dur, gap_len))
                    begin
                        job_valid = 1'b1;
                        job_kind  = JOB_GAP;
                        bst_next  = sample_time;
                        lp_next   = cur ? LP_CSYNC_HI : LP_DSYNC_LO;
                    end
                end
                default:
                begin
                    bst_next = sample_time;
                    lp_next  = cur ? LP_CSYNC_HI : LP_DSYNC_LO;
                end
            endcase
        end
        if (pushed)
        begin
            sw_push = {sw_reg[15:0], pb};
            sw_next = sw_push;
            nb_next = nb_reg + 5'd1;
            case (nb_reg)
                5'd0:  mk_next[0] = bst_reg;
                5'd6:  mk_next[1] = bst_reg;
                5'd7:  mk_next[2] = bst_reg;
                5'd11: mk_next[3] = bst_reg;
                5'd16: mk_next[4] = bst_reg;
                default: ;
            endcase
        end
        word_done = sw_push;
        if (done)
        begin
            job_valid = 1'b1;
            job_kind  = JOB_WORD;
            bst_next  = sample_time;
            sw_next   = '0;
            nb_next   = '0;
            case (fp_reg)
                FP_STATUS:
                begin
                    fp_next = dir_reg ? FP_DATA : FP_IDLE;
                    lp_next = LP_IDLE;
                end
                FP_DATA:
                begin
                    seen_next = seen_reg + 6'd1;
                    lp_next   = LP_IDLE;
                    if (seen_next >= exp_reg)
                    begin
                        if (!dir_reg)
                        begin
                            fp_next = FP_STATUS; lp_next = LP_TURN;
                        end
                        else
                            fp_next = FP_IDLE;
                    end
                end
                default:
                begin
                    dir_next = word_done[11];
                    exp_next = (word_done[5:1] == 5'd0) ? 6'd32 : {1'b0, word_done[5:1]};
                    lp_next  = word_done[11] ? LP_TURN : LP_IDLE;
                    fp_next  = word_done[11] ? FP_STATUS : FP_DATA;
                    seen_next = '0;
                end
            endcase
        end
        prev_next = cur;
    end

    assign job_t        = sample_time;
    assign job_word     = word_done;
    assign job_frame    = fp_reg;
    assign job_m0       = mk_next[0];
    assign job_m1       = mk_next[1];
    assign job_m2       = mk_next[2];
    assign job_m3       = mk_next[3];
    assign job_m4       = mk_next[4];
    assign job_expected = exp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg   <= LP_IDLE;
            fp_reg   <= FP_IDLE;
            prev_reg <= 1'b0;
            bst_reg  <= '0;
            nb_reg   <= '0;
            sw_reg   <= '0;
            seen_reg <= '0;
            exp_reg  <= '0;
            dir_reg  <= 1'b0;
        end
        else if (take)
        begin
            lp_reg   <= lp_next;
            fp_reg   <= fp_next;
            prev_reg <= prev_next;
            bst_reg  <= bst_next;
            nb_reg   <= nb_next;
            sw_reg   <= sw_next;
            seen_reg <= seen_next;
            exp_reg  <= exp_next;
            dir_reg  <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            for (int i = 0; i < 5; i++) mk_reg[i] <= mk_next[i];
    end
endmodule

// ===== rtl/core/b1553_back.sv =====
// Back part: a small job queue and a sequencer that expands each job into
// its symbols one per cycle while the output is not stalled. Uses b1553_pkg.
module b1553_back
    import b1553_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    input  job_kind_t               job_kind,
    input  logic                    job_sync_data,
    input  logic [TIME_BITS-1:0]    job_start,
    input  logic [TIME_BITS-1:0]    job_len,
    input  logic [TIME_BITS-1:0]    job_t,
    input  logic [16:0]             job_word,
    input  frame_phase_t            job_frame,
    input  logic [TIME_BITS-1:0]    job_m0,
    input  logic [TIME_BITS-1:0]    job_m1,
    input  logic [TIME_BITS-1:0]    job_m2,
    input  logic [TIME_BITS-1:0]    job_m3,
    input  logic [TIME_BITS-1:0]    job_m4,
    input  logic [5:0]              job_expected,
    output logic                    job_full,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [3:0]              symbol_kind,
    output logic [15:0]             symbol_value,
    output logic [47:0]             symbol_start,
    output logic [47:0]             symbol_length,
    output logic                    last_symbol
);
    localparam int QA = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        job_kind_t              kind;
        logic                   sdata;
        logic [TIME_BITS-1:0]   start;
        logic [TIME_BITS-1:0]   len;
        logic [TIME_BITS-1:0]   t;
        logic [16:0]            word;
        frame_phase_t           frame;
        logic [TIME_BITS-1:0]   m0;
        logic [TIME_BITS-1:0]   m1;
        logic [TIME_BITS-1:0]   m2;
        logic [TIME_BITS-1:0]   m3;
        logic [TIME_BITS-1:0]   m4;
        logic [5:0]             expct;
    } job_rec_t;

    job_rec_t       q_reg [QUEUE_DEPTH];
    logic [QA-1:0]  wp_reg, rp_reg;
    logic [QA:0]    cnt_reg, cnt_next;
    logic [2:0]     idx_reg, idx_next;
    logic           push, pop, emit_ok;
    job_rec_t       hd;
    logic [2:0]     nsym;
    logic [3:0]     k;
    logic [15:0]    v;
    logic [TIME_BITS-1:0] s, l;
    logic           par_ok;
    logic [15:0]    w;
    logic [6:0]     fl;

    assign job_full = (cnt_reg == (QA+1)'(QUEUE_DEPTH));
    assign push     = job_valid && !job_full;
    assign hd       = q_reg[rp_reg];
    assign emit_ok  = (cnt_reg != '0) && (!out_valid || !out_stall);

    always_comb
    begin
        w      = hd.word[16:1];
        par_ok = ^hd.word;
        fl     = '0;
        fl[0]  = w[9] | (|w[7:5]);
        fl[1]  = w[8];
        fl[2]  = w[4];
        fl[3]  = w[3];
        fl[4]  = w[2];
        fl[5]  = w[1];
        fl[6]  = w[0];
        k = K_GAP; v = '0; s = hd.start; l = hd.len; nsym = 3'd1;
        case (hd.kind)
            JOB_SYNC: k = hd.sdata ? K_SYNC_DATA : K_SYNC_CMD;
            JOB_GAP:  k = K_GAP;
            default:
            begin
                case (hd.frame)
                    FP_STATUS:
                    begin
                        nsym = 3'd4;
                        case (idx_reg)
                            3'd0: begin k = K_RT; v = {11'd0, w[15:11]};
                                  s = hd.m0; l = hd.m1 - hd.m0; end
                            3'd1: begin k = w[10] ? K_MSG_ERR : K_MSG_OK;
                                  s = hd.m1; l = hd.m2 - hd.m1; end
                            3'd2: begin k = K_STATUS; v = {9'd0, fl};
                                  s = hd.m2; l = hd.m4 - hd.m2; end
                            default: ;
                        endcase
                    end
                    FP_DATA:
                    begin
                        nsym = 3'd2;
                        if (idx_reg == 3'd0)
                        begin
                            k = K_DATA; v = w; s = hd.m0; l = hd.m4 - hd.m0;
                        end
                    end
                    default:
                    begin
                        nsym = 3'd5;
                        case (idx_reg)
                            3'd0: begin k = K_RT; v = {11'd0, w[15:11]};
                                  s = hd.m0; l = hd.m1 - hd.m0; end
                            3'd1: begin k = K_DIR; v = {15'd0, w[10]};
                                  s = hd.m1; l = hd.m2 - hd.m1; end
                            3'd2: begin k = K_SA; v = {11'd0, w[9:5]};
                                  s = hd.m2; l = hd.m3 - hd.m2; end
                            3'd3: begin k = K_LEN; v = {10'd0, hd.expct};
                                  s = hd.m3; l = hd.m4 - hd.m3; end
                            default: ;
                        endcase
                    end
                endcase
                // The parity symbol always closes a word.
                if (idx_reg == nsym - 3'd1)
                begin
                    k = par_ok ? K_PAR_OK : K_PAR_BAD;
                    v = {15'd0, hd.word[0]};
                    s = hd.m4; l = hd.t - hd.m4;
                end
            end
        endcase
        pop      = emit_ok && (idx_reg == nsym - 3'd1);
        idx_next = emit_ok ? (pop ? 3'd0 : idx_reg + 3'd1) : idx_reg;
        cnt_next = cnt_reg + (QA+1)'(push) - (QA+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (push) wp_reg <= wp_reg + QA'(1);
            if (pop)  rp_reg <= rp_reg + QA'(1);
            if (emit_ok)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= '{kind: job_kind, sdata: job_sync_data, start: job_start,
                               len: job_len, t: job_t, word: job_word, frame: job_frame,
                               m0: job_m0, m1: job_m1, m2: job_m2, m3: job_m3,
                               m4: job_m4, expct: job_expected};
        if (emit_ok)
        begin
            symbol_kind   <= k;
            symbol_value  <= v;
            symbol_start  <= 48'(s);
            symbol_length <= 48'(l);
            last_symbol   <= (idx_reg == nsym - 3'd1);
        end
    end
endmodule

// ===== rtl/core/bus_1553_manchester_word_decoder_unit.sv =====
// Top level of the 1553 Manchester word decoder: register port, front and back.
// Uses b1553_pkg, b1553_front and b1553_back.
// One sample is taken every cycle; the front finishes each sample in that cycle and
// queues at most one job (sync, gap or whole word) in a four-entry queue. The back
// expands a job into one to five symbols at one symbol per cycle unless stalled, so
// a sample that ends a command word yields five symbols. The input stalls only when
// the job queue is full. Registers are written through the APB port at 4*index.
module bus_1553_manchester_word_decoder_unit
    import b1553_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [TIME_BITS-1:0]    sample_time,
    input  logic [LEVEL_BITS-1:0]   line_level,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [3:0]              symbol_kind,
    output logic [15:0]             symbol_value,
    output logic [47:0]             symbol_start,
    output logic [47:0]             symbol_length,
    output logic                    last_symbol
);
    logic [15:0] high_reg, low_reg;
    logic [23:0] sync_half_reg, data_half_reg, gap_reg, sync_long_reg, bit_long_reg;
    logic [2:0]  ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg      <= 16'd2000;
            low_reg       <= 16'hF830;
            sync_half_reg <= 24'd150;
            data_half_reg <= 24'd50;
            gap_reg       <= 24'd400;
            sync_long_reg <= 24'd325;
            bit_long_reg  <= 24'd125;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                REG_HIGH:      high_reg      <= pwdata[15:0];
                REG_LOW:       low_reg       <= pwdata[15:0];
                REG_SYNC_HALF: sync_half_reg <= pwdata[23:0];
                REG_DATA_HALF: data_half_reg <= pwdata[23:0];
                REG_GAP:       gap_reg       <= pwdata[23:0];
                REG_SYNC_LONG: sync_long_reg <= pwdata[23:0];
                REG_BIT_LONG:  bit_long_reg  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_HIGH:      prdata = {16'd0, high_reg};
            REG_LOW:       prdata = {16'd0, low_reg};
            REG_SYNC_HALF: prdata = {8'd0, sync_half_reg};
            REG_DATA_HALF: prdata = {8'd0, data_half_reg};
            REG_GAP:       prdata = {8'd0, gap_reg};
            REG_SYNC_LONG: prdata = {8'd0, sync_long_reg};
            REG_BIT_LONG:  prdata = {8'd0, bit_long_reg};
            default:       prdata = '0;
        endcase
    end

    logic                 job_valid, job_sync_data, job_full;
    job_kind_t            job_kind;
    frame_phase_t         job_frame;
    logic [TIME_BITS-1:0] job_start, job_len, job_t, job_m0, job_m1, job_m2, job_m3, job_m4;
    logic [16:0]          job_word;
    logic [5:0]           job_expected;

    b1553_front #(.TIME_BITS(TIME_BITS), .LEVEL_BITS(LEVEL_BITS)) u_front (
        .clk, .rst_n, .valid(in_valid), .stall(in_stall), .sample_time, .line_level,
        .high_level(high_reg), .low_level(low_reg), .sync_half_len(sync_half_reg),
        .data_half_len(data_half_reg), .gap_len(gap_reg),
        .sync_long_limit(sync_long_reg), .bit_long_limit(bit_long_reg),
        .job_valid, .job_kind, .job_sync_data, .job_start, .job_len, .job_t,
        .job_word, .job_frame, .job_m0, .job_m1, .job_m2, .job_m3, .job_m4,
        .job_expected, .job_full
    );

    b1553_back #(.TIME_BITS(TIME_BITS)) u_back (
        .clk, .rst_n, .job_valid(job_valid && in_valid), .job_kind, .job_sync_data,
        .job_start, .job_len, .job_t, .job_word, .job_frame, .job_m0, .job_m1,
        .job_m2, .job_m3, .job_m4, .job_expected, .job_full, .out_valid, .out_stall,
        .symbol_kind, .symbol_value, .symbol_start, .symbol_length, .last_symbol
    );
endmodule

// ===== rtl/core/b1553_checker.sv =====
// Port-level checker for the 1553 word decoder, bound to the top level.
// Uses the assertion macros header and b1553_pkg.
`include "bus_1553_manchester_word_decoder_unit_defines.svh"
module b1553_checker
    import b1553_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  symbol_kind,
    input logic [15:0] symbol_value,
    input logic        last_symbol,
    input logic        pready
);
    `B1553_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(symbol_kind))
    `B1553_ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, symbol_kind <= K_DATA)
    `B1553_ASSERT_IMPL(a_parity_last, clk, rst_n,
        out_valid && (symbol_kind == K_PAR_OK || symbol_kind == K_PAR_BAD),
        last_symbol && symbol_value <= 16'd1)
    `B1553_ASSERT_IMPL(a_sync_last, clk, rst_n, out_valid && symbol_kind <= K_GAP,
        last_symbol && symbol_value == 16'd0)
    `B1553_ASSERT_IMPL(a_ready, clk, rst_n, 1'b1, pready)
endmodule

bind bus_1553_manchester_word_decoder_unit b1553_checker u_checker (
    .clk, .rst_n, .out_valid, .out_stall, .symbol_kind, .symbol_value, .last_symbol, .pready
);

// ===== tb/tb_bus_1553_manchester_word_decoder_unit.sv =====
// Self-checking testbench of the 1553 Manchester word decoder: drives sliced bus
// samples and APB register writes, predicts every symbol in SystemVerilog.
// Depends on b1553_pkg and bus_1553_manchester_word_decoder_unit.
module tb_bus_1553_manchester_word_decoder_unit
    import b1553_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] value;
        logic [47:0] start;
        logic [47:0] length;
        logic        last;
    } symbol_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [47:0] sample_time = '0;
    logic [15:0] line_level = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  symbol_kind;
    logic [15:0] symbol_value;
    logic [47:0] symbol_start;
    logic [47:0] symbol_length;
    logic        last_symbol;

    bus_1553_manchester_word_decoder_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample_time(sample_time), .line_level(line_level),
        .out_valid(out_valid), .out_stall(out_stall),
        .symbol_kind(symbol_kind), .symbol_value(symbol_value),
        .symbol_start(symbol_start), .symbol_length(symbol_length),
        .last_symbol(last_symbol)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Register copy of the decoder.
    logic signed [15:0] cfg_high = 16'sd2000;
    logic signed [15:0] cfg_low = -16'sd2000;
    logic [23:0] cfg_sync_half = 24'd150;
    logic [23:0] cfg_data_half = 24'd50;
    logic [23:0] cfg_gap = 24'd400;
    logic [23:0] cfg_sync_long = 24'd325;
    logic [23:0] cfg_bit_long = 24'd125;

    // Decoder state copy.
    line_phase_t  lphase = LP_IDLE;
    frame_phase_t fphase = FP_IDLE;
    logic         prev_level = 1'b0;
    logic [47:0]  bit_start = '0;
    logic [4:0]   bits_rx = '0;
    logic [16:0]  shift_word = '0;
    logic [5:0]   words_seen = '0;
    logic [5:0]   words_expected = '0;
    logic         tx_dir = 1'b0;
    logic [47:0]  marks [5];

    symbol_t sample_symbols[$];
    symbol_t expected_symbols[$];

    int   mismatches = 0;
    int   items_sent = 0;
    int   symbols_seen = 0;
    logic idle_on = 1'b1;
    logic hold_req = 1'b0;
    int   hold_cnt = 0;
    int   rx_wait = 0;
    logic [47:0] now = '0;

    function automatic bit is_longer(logic [47:0] d, logic [47:0] x);
        return !d[47] && d > x;
    endfunction

    task automatic emit_symbol(logic [3:0] kind, logic [15:0] value,
                               logic [47:0] start, logic [47:0] length);
        symbol_t s;
        s.kind = kind;
        s.value = value;
        s.start = start;
        s.length = length;
        s.last = 1'b0;
        sample_symbols = {sample_symbols, s};
    endtask

    task automatic shift_in_bit(logic b);
        case (bits_rx)
            5'd0:  marks[0] = bit_start;
            5'd6:  marks[1] = bit_start;
            5'd7:  marks[2] = bit_start;
            5'd11: marks[3] = bit_start;
            5'd16: marks[4] = bit_start;
            default: ;
        endcase
        shift_word = {shift_word[15:0], b};
        bits_rx = bits_rx + 5'd1;
    endtask

    task automatic predict_symbols(logic [47:0] t, logic signed [15:0] lvl);
        logic [47:0] dur;
        logic [47:0] two_half;
        logic [47:0] ptime;
        logic        cur;
        logic        edge_seen;
        logic        done;
        logic        one;
        logic        kind_data;
        logic        par;
        logic [15:0] w;
        logic [15:0] flags;
        logic [3:0]  pk;
        sample_symbols.delete();
        dur = t - bit_start;
        two_half = 48'(cfg_data_half) << 1;
        cur = prev_level;
        edge_seen = 1'b0;
        done = 1'b0;
        if (lvl > cfg_high)
        begin
            cur = 1'b1;
            edge_seen = 1'b1;
        end
        else if (lvl < cfg_low)
        begin
            cur = 1'b0;
            edge_seen = 1'b1;
        end

        // The parity bit may end on time alone.
        if (bits_rx == 5'd16 && !dur[47] && dur >= two_half)
        begin
            shift_in_bit(lphase == LP_ONE_LO);
            done = 1'b1;
            bit_start = bit_start + two_half;
            lphase = LP_TURN;
        end
        else if (edge_seen)
        begin
            case (lphase)
                LP_CSYNC_HI: if (!cur) lphase = LP_CSYNC_LO;
                LP_CSYNC_LO, LP_DSYNC_HI:
                begin
                    kind_data = (lphase == LP_DSYNC_HI);
                    if (cur == !kind_data)
                    begin
                        if (is_longer(dur, 48'(cfg_sync_long)))
                        begin
                            emit_symbol(kind_data ? K_SYNC_DATA : K_SYNC_CMD, '0, bit_start,
                                        48'(cfg_sync_half) << 1);
                            bit_start = bit_start + (48'(cfg_sync_half) << 1);
                            lphase = kind_data ? LP_ONE_LO : LP_ZERO_HI;
                        end
                        else
                        begin
                            emit_symbol(kind_data ? K_SYNC_DATA : K_SYNC_CMD, '0, bit_start,
                                        dur);
                            bit_start = t;
                            lphase = kind_data ? LP_ZERO_LO : LP_ONE_HI;
                        end
                        bits_rx = '0;
                        shift_word = '0;
                    end
                end
                LP_DSYNC_LO: if (cur) lphase = LP_DSYNC_HI;
                LP_ZERO_LO:  if (cur) lphase = LP_ZERO_HI;
                LP_ONE_HI:   if (!cur) lphase = LP_ONE_LO;
                LP_ZERO_HI, LP_ONE_LO:
                begin
                    one = (lphase == LP_ONE_LO);
                    if (cur == one)
                    begin
                        shift_in_bit(one);
                        if (bits_rx == 5'd17)
                        begin
                            done = 1'b1;
                            bit_start = bit_start + two_half;
                            lphase = LP_TURN;
                        end
                        else if (is_longer(dur, 48'(cfg_bit_long)))
                        begin
                            bit_start = bit_start + two_half;
                            lphase = one ? LP_ZERO_HI : LP_ONE_LO;
                        end
                        else
                        begin
                            bit_start = t;
                            lphase = one ? LP_ONE_HI : LP_ZERO_LO;
                        end
                    end
                end
                LP_TURN:
                begin
                    if (is_longer(dur, 48'(cfg_gap)))
                    begin
                        emit_symbol(K_GAP, '0, bit_start, dur);
                        lphase = cur ? LP_CSYNC_HI : LP_DSYNC_LO;
                        bit_start = t;
                    end
                end
                default:
                begin
                    lphase = cur ? LP_CSYNC_HI : LP_DSYNC_LO;
                    bit_start = t;
                end
            endcase
        end

        if (done)
        begin
            par = shift_word[0];
            w = shift_word[16:1];
            ptime = t - marks[4];
            pk = ($countones(w) + par) % 2 ? K_PAR_OK : K_PAR_BAD;
            bit_start = t;
            if (fphase == FP_STATUS)
            begin
                flags = '0;
                if (w & 16'h0200) flags |= 16'h01;
                if (w & 16'h0100) flags |= 16'h02;
                if (w & 16'h00e0) flags |= 16'h01;
                if (w & 16'h0010) flags |= 16'h04;
                if (w & 16'h0008) flags |= 16'h08;
                if (w & 16'h0004) flags |= 16'h10;
                if (w & 16'h0002) flags |= 16'h20;
                if (w & 16'h0001) flags |= 16'h40;
                emit_symbol(K_RT, {11'd0, w[15:11]}, marks[0], marks[1] - marks[0]);
                emit_symbol(w[10] ? K_MSG_ERR : K_MSG_OK, '0, marks[1], marks[2] - marks[1]);
                emit_symbol(K_STATUS, flags, marks[2], marks[4] - marks[2]);
                emit_symbol(pk, {15'd0, par}, marks[4], ptime);
                fphase = tx_dir ? FP_DATA : FP_IDLE;
                lphase = LP_IDLE;
            end
            else if (fphase == FP_DATA)
            begin
                words_seen = words_seen + 6'd1;
                emit_symbol(K_DATA, w, marks[0], marks[4] - marks[0]);
                emit_symbol(pk, {15'd0, par}, marks[4], ptime);
                lphase = LP_IDLE;
                if (words_seen >= words_expected)
                begin
                    if (!tx_dir)
                    begin
                        fphase = FP_STATUS;
                        lphase = LP_TURN;
                    end
                    else
                        fphase = FP_IDLE;
                end
            end
            else
            begin
                tx_dir = w[10];
                words_expected = (w[4:0] == 5'd0) ? 6'd32 : {1'b0, w[4:0]};
                emit_symbol(K_RT, {11'd0, w[15:11]}, marks[0], marks[1] - marks[0]);
                emit_symbol(K_DIR, {15'd0, tx_dir}, marks[1], marks[2] - marks[1]);
                emit_symbol(K_SA, {11'd0, w[9:5]}, marks[2], marks[3] - marks[2]);
                emit_symbol(K_LEN, {10'd0, words_expected}, marks[3], marks[4] - marks[3]);
                emit_symbol(pk, {15'd0, par}, marks[4], ptime);
                if (tx_dir)
                begin
                    lphase = LP_TURN;
                    fphase = FP_STATUS;
                end
                else
                begin
                    lphase = LP_IDLE;
                    fphase = FP_DATA;
                end
                words_seen = '0;
            end
            shift_word = '0;
            bits_rx = '0;
        end

        prev_level = cur;
        if (sample_symbols.size() > 0)
            sample_symbols[sample_symbols.size() - 1].last = 1'b1;
        foreach (sample_symbols[i])
            expected_symbols = {expected_symbols, sample_symbols[i]};
    endtask

    task automatic report(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        symbol_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            symbols_seen++;
            if (expected_symbols.size() == 0)
                report("unexpected symbol kind", 48'(symbol_kind), '0);
            else
            begin
                e = expected_symbols.pop_front();
                if (symbol_kind !== e.kind)
                    report("symbol_kind", 48'(symbol_kind), 48'(e.kind));
                if (symbol_value !== e.value)
                    report("symbol_value", 48'(symbol_value), 48'(e.value));
                if (symbol_start !== e.start) report("symbol_start", symbol_start, e.start);
                if (symbol_length !== e.length)
                    report("symbol_length", symbol_length, e.length);
                if (last_symbol !== e.last)
                    report("last_symbol", 48'(last_symbol), 48'(e.last));
            end
        end
    end

    // Long hold-off of the output, counted on its own.
    always @(posedge clk)
    begin
        if (hold_req)
            hold_cnt <= 400;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk)
    begin
        if (rx_wait > 0)
            rx_wait <= rx_wait - 1;
        else if (out_valid && !out_stall && idle_on)
            rx_wait <= $urandom_range(0, 12);
        out_stall <= (hold_cnt > 1) || hold_req || (rx_wait > 1) ||
                     (rx_wait == 0 && out_valid && !out_stall && idle_on && $urandom_range(0, 1));
    end

    task automatic send_sample(logic [47:0] t, logic [15:0] lvl);
        int gap;
        in_valid <= 1'b1;
        sample_time <= t;
        line_level <= lvl;
        do
            @(posedge clk);
        while (in_stall);
        predict_symbols(t, lvl);
        items_sent++;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_HIGH:      cfg_high = value[15:0];
            REG_LOW:       cfg_low = value[15:0];
            REG_SYNC_HALF: cfg_sync_half = value[23:0];
            REG_DATA_HALF: cfg_data_half = value[23:0];
            REG_GAP:       cfg_gap = value[23:0];
            REG_SYNC_LONG: cfg_sync_long = value[23:0];
            REG_BIT_LONG:  cfg_bit_long = value[23:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_symbols.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [15:0] drive_level(logic one);
        int v;
        v = one ? int'(cfg_high) + 1 + $urandom_range(0, 3000)
                : int'(cfg_low) - 1 - $urandom_range(0, 3000);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // One Manchester word: three half bits of sync each way, then 17 bits, sampled at
    // every half-bit boundary with small jitter. Truncated words stop early.
    task automatic send_word(logic cmd_sync, logic [15:0] w, logic bad_parity, int cut);
        logic [16:0] bits;
        logic        lv [40];
        int          n;
        int          half;
        bits = {w, ~^w ^ bad_parity};
        for (int i = 0; i < 3; i++) lv[i] = cmd_sync;
        for (int i = 3; i < 6; i++) lv[i] = !cmd_sync;
        for (int i = 0; i < 17; i++)
        begin
            lv[6 + 2 * i] = bits[16 - i];
            lv[7 + 2 * i] = !bits[16 - i];
        end
        n = (cut > 0 && cut < 40) ? cut : 40;
        half = cfg_data_half;
        for (int i = 0; i < n; i++)
        begin
            send_sample(now + 48'($urandom_range(0, half / 8)), drive_level(lv[i]));
            now = now + 48'(half);
        end
        // A quiet sample after the parity bit ends the word on time.
        now = now + 48'(half);
        send_sample(now, 16'd0);
        now = now + 48'(cfg_gap) + 48'(half);
    endtask

    task automatic send_transaction(logic [4:0] rt, logic dir, logic [4:0] count,
                                    logic broken);
        int words;
        int cut;
        words = (count == 0) ? 32 : count;
        cut = broken ? $urandom_range(4, 38) : 0;
        send_word(1'b1, {rt, dir, 5'($urandom), count}, 1'b0, 0);
        if (dir)
            send_word(1'b1, {rt, 11'($urandom)}, broken && $urandom_range(0, 1), cut);
        for (int i = 0; i < words; i++)
            send_word(1'b0, 16'($urandom), $urandom_range(0, 15) == 0,
                      (i == words - 1) ? cut : 0);
        if (!dir)
            send_word(1'b1, {rt, 11'($urandom)}, $urandom_range(0, 15) == 0, 0);
    endtask

    task automatic test_field_extremes();
        send_sample(48'h0, 16'h7fff);
        send_sample(48'hffff_ffff_ffff, 16'h8000);
        send_sample(48'h0, 16'h0000);
        send_sample(48'h5555_5555_5555, 16'hffff);
        send_sample(48'haaaa_aaaa_aaaa, 16'h7fff);
        send_sample(48'h0000_0000_0100, 16'h8000);
        now = 48'h0000_0001_0000;
        send_sample(now, 16'd0);
        now = now + 48'd1000;
    endtask

    task automatic test_bc_to_rt();
        send_transaction(5'd3, 1'b0, 5'd1, 1'b0);
    endtask

    // The sender runs without gaps while the output is held, so the job queue fills.
    task automatic test_rt_to_bc_under_hold();
        idle_on <= 1'b0;
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        send_transaction(5'd17, 1'b1, 5'd1, 1'b0);
        idle_on <= 1'b1;
    endtask

    // A command word with a word count of zero, crossing the top of the time range.
    task automatic test_time_wrap();
        now = 48'hffff_ffff_fc00;
        send_word(1'b1, {5'd31, 1'b0, 5'd4, 5'd0}, 1'b0, 0);
    endtask

    task automatic test_random_traffic(int target);
        int cut;
        while (items_sent < target)
        begin
            idle_on <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
            begin
                for (int i = 0; i < 6; i++)
                    send_sample(48'({$urandom, $urandom}), 16'($urandom));
                now = now + 48'd2000;
                send_sample(now, 16'd0);
                now = now + 48'd2000;
            end
            else
            begin
                cut = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 38) : 0;
                send_word(1'($urandom), 16'($urandom), $urandom_range(0, 15) == 0, cut);
            end
        end
        idle_on <= 1'b1;
    endtask

    task automatic test_fast_timing();
        wait_drained();
        apb_write(REG_DATA_HALF, 32'd20);
        apb_write(REG_SYNC_HALF, 32'd60);
        apb_write(REG_GAP, 32'd160);
        apb_write(REG_SYNC_LONG, 32'd130);
        apb_write(REG_BIT_LONG, 32'd50);
        apb_write(REG_HIGH, 32'd1000);
        apb_write(REG_LOW, 32'hffff_fc18);
        send_word(1'b0, 16'($urandom), 1'b0, 0);
        send_word(1'b1, 16'($urandom), 1'b1, 20);
    endtask

    task automatic test_register_extremes();
        wait_drained();
        apb_write(REG_HIGH, 32'h0000_7fff);
        apb_write(REG_LOW, 32'h0000_8000);
        for (int i = 0; i < 8; i++)
            send_sample(48'({$urandom, $urandom}), 16'($urandom));
        wait_drained();
        apb_write(REG_HIGH, 32'h0000_8000);
        apb_write(REG_LOW, 32'h0000_7fff);
        apb_write(REG_DATA_HALF, 32'h00ff_ffff);
        apb_write(REG_GAP, 32'd1);
        apb_write(REG_SYNC_LONG, 32'd1);
        apb_write(REG_BIT_LONG, 32'hffff_ffff);
        apb_write(REG_SYNC_HALF, 32'h00ff_ffff);
        for (int i = 0; i < 12; i++)
            send_sample(48'({$urandom, $urandom}), 16'($urandom));
        wait_drained();
        apb_write(REG_HIGH, 32'd2000);
        apb_write(REG_LOW, 32'hffff_f830);
        apb_write(REG_SYNC_HALF, 32'd150);
        apb_write(REG_DATA_HALF, 32'd50);
        apb_write(REG_GAP, 32'd400);
        apb_write(REG_SYNC_LONG, 32'd325);
        apb_write(REG_BIT_LONG, 32'd125);
        now = now + 48'd5000;
    endtask

    initial
    begin
        for (int i = 0; i < 5; i++) marks[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_bc_to_rt();
        test_rt_to_bc_under_hold();
        test_time_wrap();
        test_fast_timing();
        test_register_extremes();
        test_random_traffic(380);
        wait_drained();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
